@@ sv/lfa_pkg.sv @@
// Shared types and constants for the lowest free ID allocator.
package lfa_pkg;

  localparam int unsigned ID_W       = 6;
  localparam int unsigned SLOT_W_IN  = 6;
  localparam int unsigned CHUNK_BITS = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  typedef logic [ID_W-1:0]      id_t;
  typedef logic [SLOT_W_IN-1:0] slot_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic {
    REG_MAX_ID_ZERO = 1'b0,
    REG_MAX_ID_ONE  = 1'b1
  } reg_e;

  localparam id_t MAX_ID_RESET = 6'd63;

endpackage

@@ sv/lfa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module lfa_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lowest_free_id_allocator_top.sv @@
// Lowest free ID allocator: ID table in RAM, slot scan and chunked free-ID search.
//
// Input channel (in_valid_i / in_stall_o) carries one request per transfer:
// req_type_i = write stores entry_id_i for (slot_i, module_req_i); a query
// returns the lowest ID from 1 to the module's maximum not held by any other
// slot. Each request gives one transfer on the output channel
// (out_valid_o / out_stall_i): free_id_o and found_o, zero for a write.
// A write passes from idle through the response state into the output
// register. A query scans the table one slot per cycle through the RAM read
// port, then searches the used map eight IDs per cycle, and its result then
// passes through the response state into the output register. One request
// is in work at a time; the next is taken as soon as its result sits in the
// output register, even while that is stalled. After reset the table is
// cleared one entry per cycle, all SLOT_COUNT * MODULE_COUNT entries (128 by
// default), with in_stall_o high; the APB port is live throughout. Both
// maxima reset to 63. A stalled result holds until it is taken; the next one
// is loaded into the output register in the same cycle as the stalled one is taken.
module lowest_free_id_allocator_top #(
  parameter int unsigned SLOT_COUNT   = 64,
  parameter int unsigned MODULE_COUNT = 2,
  parameter int unsigned ID_SPACE     = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  lfa_pkg::slot_t                  slot_i,
  input  logic                            module_req_i,
  input  lfa_pkg::id_t                    entry_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lfa_pkg::id_t                    free_id_o,
  output logic                            found_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lfa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lfa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lfa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import lfa_pkg::*;

  localparam int unsigned DEPTH   = SLOT_COUNT * MODULE_COUNT;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned SLOT_W  = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CHUNKS  = (ID_SPACE + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned MAP_W   = CHUNKS * CHUNK_BITS;
  localparam int unsigned CHK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]    iss_cnt_q, iss_cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]   rd_slot_q, rd_slot_d;
  slot_t               qry_slot_q, qry_slot_d;
  logic                qry_mod_q, qry_mod_d;
  id_t                 lim_q, lim_d;
  logic [MAP_W-1:0]    used_q, used_d;
  logic [CHK_W-1:0]    chk_q, chk_d;
  id_t                 res_id_q, res_id_d;
  logic                out_valid_q, out_valid_d;
  id_t                 free_id_q, free_id_d;
  logic                found_q, found_d;
  id_t                 max0_q, max1_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  id_t                 ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  id_t                 ram_rdata;

  logic                in_acc;
  logic                mod_ok;
  logic                wr_ok;
  id_t                 lim_in;
  logic [ADDR_W-1:0]   wr_addr;
  logic                mark_hit;
  logic [MAP_W-1:0]    mark_vec;
  logic                chunk_hit;
  id_t                 chunk_id;
  logic                cfg_wr;
  reg_e                reg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MAX_ID_ZERO: prdata[ID_W-1:0] = max0_q;
      REG_MAX_ID_ONE:  prdata[ID_W-1:0] = max1_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max0_q <= MAX_ID_RESET;
      max1_q <= MAX_ID_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_ID_ZERO: max0_q <= pwdata[ID_W-1:0];
        REG_MAX_ID_ONE:  max1_q <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign mod_ok     = (int'(module_req_i) < MODULE_COUNT);
  assign wr_ok      = mod_ok && (int'(slot_i) < SLOT_COUNT);
  assign wr_addr    = ADDR_W'(int'(slot_i) * MODULE_COUNT + int'(module_req_i));

  always_comb begin
    lim_in = (module_req_i == 1'b0) ? max0_q : max1_q;
    if (int'(lim_in) > ID_SPACE - 1) begin
      lim_in = ID_W'(ID_SPACE - 1);
    end
  end

  // Scan: mark IDs held by other slots
  assign mark_hit = rd_vld_q && (int'(rd_slot_q) != int'(qry_slot_q)) &&
                    (ram_rdata != '0) && (int'(ram_rdata) < ID_SPACE);

  always_comb begin
    for (int b = 0; b < MAP_W; b++) begin
      mark_vec[b] = (int'(ram_rdata) == b);
    end
  end

  // Search: eight IDs per cycle
  always_comb begin
    logic [CHUNK_BITS-1:0] bits;
    int                    idv;
    bits      = used_q[int'(chk_q) * CHUNK_BITS +: CHUNK_BITS];
    chunk_hit = 1'b0;
    chunk_id  = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      idv = int'(chk_q) * CHUNK_BITS + j;
      if (!chunk_hit && !bits[j] && (idv >= 1) && (idv <= int'(lim_q))) begin
        chunk_hit = 1'b1;
        chunk_id  = ID_W'(idv);
      end
    end
  end

  assign ram_raddr = ADDR_W'(int'(iss_cnt_q[SLOT_W-1:0]) * MODULE_COUNT + int'(qry_mod_q));

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    iss_cnt_d   = iss_cnt_q;
    rd_vld_d    = rd_vld_q;
    rd_slot_d   = rd_slot_q;
    qry_slot_d  = qry_slot_q;
    qry_mod_d   = qry_mod_q;
    lim_d       = lim_q;
    used_d      = used_q;
    chk_d       = chk_q;
    res_id_d    = res_id_q;
    out_valid_d = out_valid_q && out_stall_i;
    free_id_d   = free_id_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr;
    ram_wdata   = entry_id_i;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_id_d = '0;
          if (req_e'(req_type_i) == REQ_WRITE) begin
            ram_we  = wr_ok;
            state_d = ST_RESP;
          end else if (!mod_ok) begin
            state_d = ST_RESP;
          end else begin
            qry_slot_d = slot_i;
            qry_mod_d  = module_req_i;
            lim_d      = lim_in;
            used_d     = '0;
            iss_cnt_d  = '0;
            rd_vld_d   = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mark_hit) begin
          used_d = used_q | mark_vec;
        end
        if (int'(iss_cnt_q) != SLOT_COUNT) begin
          rd_vld_d  = 1'b1;
          rd_slot_d = iss_cnt_q[SLOT_W-1:0];
          iss_cnt_d = iss_cnt_q + CNT_W'(1);
        end else begin
          rd_vld_d = 1'b0;
          if (!rd_vld_q) begin
            chk_d   = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (chunk_hit) begin
          res_id_d = chunk_id;
          state_d  = ST_RESP;
        end else if (chk_q == CHK_W'(CHUNKS - 1)) begin
          state_d = ST_RESP;
        end else begin
          chk_d = chk_q + CHK_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          free_id_d   = res_id_q;
          found_d     = (res_id_q != '0);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      iss_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      rd_slot_q   <= '0;
      qry_slot_q  <= '0;
      qry_mod_q   <= 1'b0;
      lim_q       <= '0;
      used_q      <= '0;
      chk_q       <= '0;
      res_id_q    <= '0;
      out_valid_q <= 1'b0;
      free_id_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      iss_cnt_q   <= iss_cnt_d;
      rd_vld_q    <= rd_vld_d;
      rd_slot_q   <= rd_slot_d;
      qry_slot_q  <= qry_slot_d;
      qry_mod_q   <= qry_mod_d;
      lim_q       <= lim_d;
      used_q      <= used_d;
      chk_q       <= chk_d;
      res_id_q    <= res_id_d;
      out_valid_q <= out_valid_d;
      free_id_q   <= free_id_d;
      found_q     <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign free_id_o   = free_id_q;
  assign found_o     = found_q;

  lfa_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_found_matches_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o == (free_id_o != '0)))
    else $error("found flag disagrees with free ID");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SEARCH) |-> !ram_we)
    else $error("table written during a query");

  a_read_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("read data in flight outside the scan");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (int'(iss_cnt_q) <= SLOT_COUNT))
    else $error("slot scan ran past the table");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("request transfer did not start work");
`endif

endmodule

@@ test/tb_lowest_free_id_allocator_top.sv @@
// Self-checking testbench for the lowest free ID allocator top level.
`timescale 1ns / 1ps

module tb_lowest_free_id_allocator_top;
  import lfa_pkg::*;

  localparam int unsigned SLOT_COUNT   = 64;
  localparam int unsigned MODULE_COUNT = 2;
  localparam int unsigned ID_SPACE     = 64;
  localparam int unsigned PHASES       = 8;

  typedef struct packed {
    req_e  kind;
    slot_t slot;
    logic  mod_sel;
    id_t   entry;
  } alloc_req_t;

  typedef struct packed {
    id_t  free_id;
    logic found;
  } alloc_rsp_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i   = 1'b0;
  slot_t                 slot_i       = '0;
  logic                  module_req_i = 1'b0;
  id_t                   entry_id_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  id_t                   free_id_o;
  logic                  found_o;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [CFG_DATA_W-1:0] pwdata       = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  alloc_req_t req_q[$];
  alloc_rsp_t answer_q[$];
  alloc_req_t drv_item;
  alloc_rsp_t want;

  id_t         id_tab [SLOT_COUNT][MODULE_COUNT];
  id_t         max_id [MODULE_COUNT];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;

  int unsigned lims0 [PHASES] = '{63, 1, 0, 17, 63, 8, 31, 63};
  int unsigned lims1 [PHASES] = '{63, 63, 5, 40, 1, 0, 63, 0};

  lowest_free_id_allocator_top #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MODULE_COUNT(MODULE_COUNT),
    .ID_SPACE    (ID_SPACE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .slot_i      (slot_i),
    .module_req_i(module_req_i),
    .entry_id_i  (entry_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .free_id_o   (free_id_o),
    .found_o     (found_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic id_t lowest_free_id(slot_t skip, logic mod_sel);
    logic [ID_SPACE-1:0] taken;
    int unsigned         lim;
    taken = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (s != skip && id_tab[s][mod_sel] != '0) taken[id_tab[s][mod_sel]] = 1'b1;
    end
    lim = max_id[mod_sel];
    if (lim > ID_SPACE - 1) lim = ID_SPACE - 1;
    for (int i = 1; i <= lim; i++) begin
      if (!taken[i]) return id_t'(i);
    end
    return '0;
  endfunction

  function automatic alloc_rsp_t serve_request(alloc_req_t r);
    alloc_rsp_t rsp;
    rsp = '0;
    if (r.kind == REQ_WRITE) begin
      id_tab[r.slot][r.mod_sel] = r.entry;
    end else begin
      rsp.free_id = lowest_free_id(r.slot, r.mod_sel);
      rsp.found   = (rsp.free_id != '0);
    end
    return rsp;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) answer_q.push_back(serve_request(drv_item));
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = req_q.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= drv_item.kind;
          slot_i       <= drv_item.slot;
          module_req_i <= drv_item.mod_sel;
          entry_id_i   <= drv_item.entry;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got free_id %0d found %0b",
                 $time, free_id_o, found_o);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (free_id_o !== want.free_id) begin
          $display("%0t: free_id expected %0d, got %0d", $time, want.free_id, free_id_o);
          errors++;
        end
        if (found_o !== want.found) begin
          $display("%0t: found expected %0b, got %0b", $time, want.found, found_o);
          errors++;
        end
      end
    end
  end

  task automatic push_write(slot_t slot, logic mod_sel, id_t entry);
    req_q.push_back('{kind: REQ_WRITE, slot: slot, mod_sel: mod_sel, entry: entry});
  endtask

  task automatic push_query(slot_t slot, logic mod_sel);
    req_q.push_back('{kind: REQ_QUERY, slot: slot, mod_sel: mod_sel, entry: id_t'($urandom)});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || answer_q.size() != 0);
  endtask

  task automatic set_max(reg_e idx, int unsigned lim);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom_range(1) ? ($urandom() & 32'hffff_ffc0) : '0;
    data[ID_W-1:0] = id_t'(lim);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_id[idx] = data[ID_W-1:0];
    @(negedge clk_i);
  endtask

  // runs of consecutive IDs make the table dense, the rest is loose traffic
  task automatic fill_phase(int unsigned n, int unsigned lim0, int unsigned lim1);
    int unsigned cnt;
    int unsigned sel;
    int unsigned lim;
    int unsigned base;
    int unsigned run;
    logic        mod_sel;
    cnt = 0;
    while (cnt < n) begin
      sel     = $urandom_range(9);
      mod_sel = $urandom_range(1);
      lim     = mod_sel ? lim1 : lim0;
      if (lim == 0) lim = 8;
      if (sel < 3) begin
        base = $urandom_range(63);
        run  = $urandom_range(lim + 1, 1);
        for (int j = 0; j < run; j++) push_write(slot_t'(base + j), mod_sel, id_t'(j % lim + 1));
        if ($urandom_range(1)) push_write(slot_t'(base + $urandom_range(run - 1)), mod_sel, '0);
        if ($urandom_range(1)) push_query(slot_t'(base), mod_sel);
        else push_query(slot_t'($urandom), mod_sel);
        cnt += run + 2;
      end else if (sel < 7) begin
        push_write(slot_t'($urandom), mod_sel, id_t'($urandom));
        cnt++;
      end else begin
        push_query(slot_t'($urandom), mod_sel);
        cnt++;
      end
    end
  endtask

  initial begin
    foreach (id_tab[s, m]) id_tab[s][m] = '0;
    max_id[0] = MAX_ID_RESET;
    max_id[1] = MAX_ID_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_query(6'd0, 1'b0);
    push_write(6'd0, 1'b0, 6'd1);
    push_write(6'd63, 1'b0, 6'd2);
    push_query(6'd0, 1'b0);
    push_query(6'd63, 1'b0);
    push_query(6'd10, 1'b0);
    push_write(6'd42, 1'b1, 6'd63);
    push_query(6'd0, 1'b1);
    push_write(6'd21, 1'b1, 6'd42);
    push_write(6'd0, 1'b0, 6'd0);
    push_query(6'd10, 1'b0);
    wait_drained();

    // low maximum so that every ID is taken, and a maximum of zero
    set_max(REG_MAX_ID_ZERO, 2);
    set_max(REG_MAX_ID_ONE, 0);
    push_write(6'd5, 1'b0, 6'd1);
    push_write(6'd6, 1'b0, 6'd2);
    push_query(6'd7, 1'b0);
    push_query(6'd5, 1'b0);
    push_query(6'd0, 1'b1);
    push_write(6'd7, 1'b0, 6'd63);
    push_query(6'd8, 1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_max(REG_MAX_ID_ZERO, lims0[p]);
      set_max(REG_MAX_ID_ONE, lims1[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      fill_phase(185, lims0[p], lims1[p]);
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
